// ----- src/wspp_pkg.sv -----
// Shared types and constants for the wheel speed PID/PWM block.
// Used by the serial multiplier, the top level and the port checker.
// No dependencies.
`default_nettype none

package wspp_pkg;

  // Serial multiplier geometry: 4-bit digits of a 24-bit unsigned gain
  // against a 34-bit signed operand, result taken after a 16-bit shift.
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned MR_W   = 24;
  localparam int unsigned MC_W   = 34;
  localparam int unsigned N_STEP = MR_W / DIG_W;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = MC_W + MR_W - FRAC_W;

  // Port widths
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_CH0    = 3'd0,
    REG_KI_CH0    = 3'd1,
    REG_KD_CH0    = 3'd2,
    REG_KP_CH1    = 3'd3,
    REG_KI_CH1    = 3'd4,
    REG_KD_CH1    = 3'd5,
    REG_PWM_LIMIT = 3'd6,
    REG_ALPHA     = 3'd7
  } cfg_reg_e;

  // Duty warning codes
  typedef enum logic [1:0] {
    WARN_NONE = 2'd0,
    WARN_HIGH = 2'd1,
    WARN_NEG  = 2'd2
  } warn_e;

  // Multiplier request and response
  typedef struct packed {
    logic                     start;
    logic signed [MC_W-1:0]   mcand;
    logic        [MR_W-1:0]   mult;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ----- src/wspp_ser_mul.sv -----
// Digit-serial signed-by-unsigned multiplier, one 4-bit digit per cycle,
// returning floor(mcand * mult / 2^16). Depends on wspp_pkg.
`default_nettype none

module wspp_ser_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wspp_pkg::mul_req_t req_i,
  output wspp_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned ACC_W = wspp_pkg::MC_W + wspp_pkg::DIG_W;
  localparam int unsigned SUM_W = ACC_W + 1;
  localparam int unsigned CNT_W = $clog2(wspp_pkg::N_STEP + 1);

  logic signed [wspp_pkg::MC_W-1:0] mc_q;
  logic        [wspp_pkg::MR_W-1:0] mr_q, mr_d;
  logic        [wspp_pkg::MR_W-1:0] lo_q, lo_d;
  logic signed [ACC_W-1:0]          acc_q, acc_d;
  logic        [CNT_W-1:0]          cnt_q, cnt_d;
  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic signed [wspp_pkg::DIG_W:0]  dig;
  logic signed [SUM_W-1:0]          pp;
  logic signed [SUM_W-1:0]          sum;

  // Partial product of the current low digit, added to the running high part
  assign dig = $signed({1'b0, mr_q[wspp_pkg::DIG_W-1:0]});
  assign pp  = SUM_W'(mc_q) * SUM_W'(dig);
  assign sum = $signed({acc_q[ACC_W-1], acc_q}) + pp;

  // Load on start, otherwise shift one digit per cycle while busy
  always_comb begin
    mr_d   = mr_q;
    lo_d   = lo_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      mr_d   = req_i.mult;
      lo_d   = '0;
      acc_d  = '0;
      cnt_d  = CNT_W'(wspp_pkg::N_STEP);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = ACC_W'(sum >>> wspp_pkg::DIG_W);
      lo_d  = {sum[wspp_pkg::DIG_W-1:0], lo_q[wspp_pkg::MR_W-1:wspp_pkg::DIG_W]};
      mr_d  = mr_q >> wspp_pkg::DIG_W;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mc_q <= req_i.mcand;
    end
    mr_q  <= mr_d;
    lo_q  <= lo_d;
    acc_q <= acc_d;
  end

  // High part is bounded by the operand, so its low MC_W bits carry the sign
  assign rsp_o.done = done_q;
  assign rsp_o.prod = $signed({acc_q[wspp_pkg::MC_W-1:0],
                               lo_q[wspp_pkg::MR_W-1:wspp_pkg::FRAC_W]});

endmodule

`default_nettype wire

// ----- src/wheel_speed_pid_pwm.sv -----
// Two-channel wheel speed PID controller with saturating PWM accumulator.
// Depends on wspp_pkg and wspp_ser_mul.
//
//  channel   dir  handshake                     payload
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: target, measured; tuser: channel
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: duty, reverse, warning, pid_sum;
//                                               tuser: channel
//
// An accepted item goes through SETUP, four products, SUM and ACC before EMIT loads its
// result into the output register; a zero target skips to ACC. Four products (P, I, filter,
// D) go one after another through one 4-bit digit-serial multiplier, each as start, six
// digit steps and collect. One item is worked at a time; the next is accepted while a
// result waits at m_axis, and a result that finds m_axis still full holds the datapath.
// Reset clears gains, limits and all per-channel controller state.
`default_nettype none

module wheel_speed_pid_pwm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wspp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wspp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] target_speed, [46:24] measured_speed, [47] zero fill
  input  logic [wspp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] channel
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] duty, [16] reverse, [18:17] warning, [50:19] pid_sum, [55:51] zero fill
  output logic [wspp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] channel_out
  output logic                               m_axis_tuser
);

  localparam int unsigned SP_W   = 24;
  localparam int unsigned MEAS_W = 23;
  localparam int unsigned ERR_W  = SP_W + 1;
  localparam int unsigned INT_W  = 16;
  localparam int unsigned S32_W  = 32;
  localparam int unsigned LIM_W  = 16;
  localparam int unsigned WIDE_W = wspp_pkg::PROD_W + 2;
  localparam int unsigned V_W    = S32_W - 8 + 1;

  localparam logic signed [INT_W-1:0] TERM_MAX = 16'sd12800;
  localparam logic signed [INT_W-1:0] TERM_MIN = -16'sd12800;
  localparam logic signed [S32_W-1:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [S32_W-1:0] S32_MIN  = 32'sh8000_0000;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_ACC   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    OP_P = 2'd0,
    OP_I = 2'd1,
    OP_F = 2'd2,
    OP_D = 2'd3
  } op_e;

  function automatic logic signed [INT_W-1:0] sat_term(input logic signed [WIDE_W-1:0] x);
    if (x > TERM_MAX) begin
      return TERM_MAX;
    end else if (x < TERM_MIN) begin
      return TERM_MIN;
    end
    return $signed(x[INT_W-1:0]);
  endfunction

  function automatic logic signed [S32_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    if (x > S32_MAX) begin
      return S32_MAX;
    end else if (x < S32_MIN) begin
      return S32_MIN;
    end
    return $signed(x[S32_W-1:0]);
  endfunction

  // Configuration registers
  logic [wspp_pkg::MR_W-1:0] kp_q [2];
  logic [wspp_pkg::MR_W-1:0] ki_q [2];
  logic [wspp_pkg::MR_W-1:0] kd_q [2];
  logic [LIM_W-1:0]          lim_q;
  logic [LIM_W-1:0]          alpha_q;

  // Per-channel controller state
  logic signed [INT_W-1:0] integ_q [2];
  logic signed [S32_W-1:0] filt_q  [2];
  logic        [SP_W-1:0]  last_q  [2];
  logic signed [S32_W-1:0] accum_q [2];

  // Sequencer
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   start_q, start_d;

  // Item payload
  logic                             ch_q;
  logic                             rev_q;
  logic                             zero_q;
  logic        [SP_W-1:0]           sp_q;
  logic        [MEAS_W-1:0]         meas_q;
  logic signed [ERR_W-1:0]          err_q;
  logic signed [ERR_W-1:0]          delta_q;
  logic signed [wspp_pkg::MC_W-1:0] dmf_q;
  logic signed [wspp_pkg::PROD_W-1:0] p_q;
  logic signed [INT_W-1:0]          d_q;
  logic signed [S32_W-1:0]          sum_q;
  logic signed [S32_W-1:0]          acc_q;

  // Output register
  logic                  out_valid_q;
  logic                  out_ch_q;
  logic [LIM_W-1:0]      out_duty_q;
  logic                  out_rev_q;
  wspp_pkg::warn_e       out_warn_q;
  logic signed [S32_W-1:0] out_sum_q;

  // Combinational helpers
  logic                     in_acc;
  logic                     in_zero;
  logic signed [SP_W-1:0]   in_tgt;
  logic        [SP_W-1:0]   in_sp;
  logic                     slot_free;
  logic                     emit_load;
  logic                     col_p, col_i, col_f, col_d;
  logic signed [WIDE_W-1:0] prod_x;
  logic signed [WIDE_W-1:0] isum, fsum, psum, asum;
  logic signed [S32_W-1:0]  acc_next;
  logic signed [S32_W:0]    acc_adj;
  logic signed [V_W-1:0]    v;
  logic signed [V_W-1:0]    lim_x, lim2_x;
  logic [LIM_W-1:0]         duty_d;
  wspp_pkg::warn_e          warn_d;
  wspp_pkg::mul_req_t       mul_req;
  wspp_pkg::mul_rsp_t       mul_rsp;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_tgt        = $signed(s_axis_tdata[SP_W-1:0]);
  assign in_zero       = (in_tgt == '0);
  assign in_sp         = in_tgt[SP_W-1] ? (~s_axis_tdata[SP_W-1:0] + 1'b1)
                                        : s_axis_tdata[SP_W-1:0];
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign emit_load     = (state_q == ST_EMIT) && slot_free;

  // Product collection strobes
  assign col_p = (state_q == ST_MUL) && mul_rsp.done && (op_q == OP_P);
  assign col_i = (state_q == ST_MUL) && mul_rsp.done && (op_q == OP_I);
  assign col_f = (state_q == ST_MUL) && mul_rsp.done && (op_q == OP_F);
  assign col_d = (state_q == ST_MUL) && mul_rsp.done && (op_q == OP_D);

  // Combine products with stored state
  assign prod_x = WIDE_W'(mul_rsp.prod);
  assign isum   = WIDE_W'(integ_q[ch_q]) + prod_x;
  assign fsum   = WIDE_W'(filt_q[ch_q]) + prod_x;
  assign psum   = WIDE_W'(p_q) + WIDE_W'(integ_q[ch_q]) + WIDE_W'(d_q);
  assign asum   = WIDE_W'(accum_q[ch_q]) + WIDE_W'(sum_q);
  assign acc_next = zero_q ? '0 : sat32(asum);

  // Truncate accumulator toward zero to whole duty steps
  assign acc_adj = $signed({acc_q[S32_W-1], acc_q})
                 + (acc_q[S32_W-1] ? (S32_W+1)'(255) : (S32_W+1)'(0));
  assign v       = $signed(acc_adj[S32_W:8]);
  assign lim_x   = $signed({{(V_W-LIM_W){1'b0}}, lim_q});
  assign lim2_x  = $signed({{(V_W-LIM_W-1){1'b0}}, lim_q, 1'b0});

  // Limit duty and flag out-of-range values
  always_comb begin
    duty_d = v[LIM_W-1:0];
    warn_d = wspp_pkg::WARN_NONE;
    if (v > lim2_x) begin
      duty_d = lim_q;
      warn_d = wspp_pkg::WARN_HIGH;
    end else if (v > lim_x) begin
      duty_d = lim_q;
    end else if (v < 0) begin
      duty_d = '0;
      warn_d = wspp_pkg::WARN_NEG;
    end
  end

  // Select multiplier operands for the current product
  always_comb begin
    mul_req.start = start_q;
    unique case (op_q)
      OP_P: begin
        mul_req.mcand = wspp_pkg::MC_W'(err_q);
        mul_req.mult  = kp_q[ch_q];
      end
      OP_I: begin
        mul_req.mcand = wspp_pkg::MC_W'(err_q);
        mul_req.mult  = ki_q[ch_q];
      end
      OP_F: begin
        mul_req.mcand = dmf_q;
        mul_req.mult  = wspp_pkg::MR_W'(alpha_q);
      end
      OP_D: begin
        mul_req.mcand = wspp_pkg::MC_W'(filt_q[ch_q]);
        mul_req.mult  = kd_q[ch_q];
      end
      default: begin
        mul_req.mcand = '0;
        mul_req.mult  = '0;
      end
    endcase
  end

  wspp_ser_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    start_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = in_zero ? ST_ACC : ST_SETUP;
        end
      end
      ST_SETUP: begin
        op_d    = OP_P;
        start_d = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          unique case (op_q)
            OP_P: begin
              op_d    = OP_I;
              start_d = 1'b1;
            end
            OP_I: begin
              op_d    = OP_F;
              start_d = 1'b1;
            end
            OP_F: begin
              op_d    = OP_D;
              start_d = 1'b1;
            end
            OP_D:    state_d = ST_SUM;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUM:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_P;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      start_q <= start_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '{default: '0};
      ki_q    <= '{default: '0};
      kd_q    <= '{default: '0};
      lim_q   <= '0;
      alpha_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wspp_pkg::REG_KP_CH0:    kp_q[0] <= cfg_data_i;
        wspp_pkg::REG_KI_CH0:    ki_q[0] <= cfg_data_i;
        wspp_pkg::REG_KD_CH0:    kd_q[0] <= cfg_data_i;
        wspp_pkg::REG_KP_CH1:    kp_q[1] <= cfg_data_i;
        wspp_pkg::REG_KI_CH1:    ki_q[1] <= cfg_data_i;
        wspp_pkg::REG_KD_CH1:    kd_q[1] <= cfg_data_i;
        wspp_pkg::REG_PWM_LIMIT: lim_q   <= cfg_data_i[LIM_W-1:0];
        wspp_pkg::REG_ALPHA:     alpha_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '{default: '0};
      filt_q  <= '{default: '0};
      last_q  <= '{default: '0};
      accum_q <= '{default: '0};
    end else begin
      if (col_i) begin
        integ_q[ch_q] <= sat_term(isum);
      end
      if (col_f) begin
        filt_q[ch_q] <= sat32(fsum);
        last_q[ch_q] <= sp_q;
      end
      if (state_q == ST_ACC) begin
        accum_q[ch_q] <= acc_next;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= s_axis_tuser;
      rev_q  <= in_tgt[SP_W-1];
      zero_q <= in_zero;
      sp_q   <= in_sp;
      meas_q <= s_axis_tdata[SP_W +: MEAS_W];
      sum_q  <= '0;
    end
    if (state_q == ST_SETUP) begin
      err_q   <= $signed({1'b0, sp_q}) - $signed({2'b0, meas_q});
      delta_q <= $signed({1'b0, sp_q}) - $signed({1'b0, last_q[ch_q]});
    end
    if (col_p) begin
      p_q   <= mul_rsp.prod;
      dmf_q <= wspp_pkg::MC_W'(delta_q) - wspp_pkg::MC_W'(filt_q[ch_q]);
    end
    if (col_d) begin
      d_q <= sat_term(prod_x);
    end
    if (state_q == ST_SUM) begin
      sum_q <= sat32(psum);
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_next;
    end
    if (emit_load) begin
      out_ch_q   <= ch_q;
      out_duty_q <= duty_d;
      out_rev_q  <= rev_q;
      out_warn_q <= warn_d;
      out_sum_q  <= sum_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tdata  = {5'b0, out_sum_q, out_warn_q, out_rev_q, out_duty_q};

endmodule

`default_nettype wire

// ----- src/wspp_chk.sv -----
// Port-level checker for wheel_speed_pid_pwm, attached by bind.
// Depends on wspp_pkg.
`default_nettype none

module wspp_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wspp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);

  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       in_acc;
  logic       out_acc;
  logic [1:0] warn;
  logic [15:0] duty;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign warn    = m_axis_tdata[18:17];
  assign duty    = m_axis_tdata[15:0];

  // Track transactions accepted but not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_warn_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (warn == wspp_pkg::WARN_NONE) || (warn == wspp_pkg::WARN_HIGH) ||
                      ((warn == wspp_pkg::WARN_NEG) && (duty == 16'd0)))
    else $error("bad warning code or nonzero duty on negative value");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more than two transactions in flight");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !s_axis_tready)
    else $error("input taken with output register and datapath both busy");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !m_axis_tvalid)
    else $error("result offered with nothing in flight");

endmodule

bind wheel_speed_pid_pwm wspp_chk u_wspp_chk (.*);

`default_nettype wire
